// ===== rtl/core/mcf_pkg.sv =====
// Shared types and constants of the filled-circle span generator.
// Used by the front end, the command queue users and the top level; no dependencies.
`timescale 1ns / 1ps

package mcf_pkg;

   // Default radius width and span command queue depth.
   localparam int RADIUS_BITS_DEF = 12;
   localparam int CMD_DEPTH_DEF   = 2;

   // Fixed widths of the channel fields.
   localparam int COORD_W = 16;
   localparam int RAD_W   = 12;
   localparam int SPAN_W  = 17;
   // Walk coordinates carried in a command, sized for the largest radius width.
   localparam int STEP_W  = 16;

   typedef enum logic {
      ACT_START   = 1'b0,
      ACT_ADVANCE = 1'b1
   } action_type;

   // One command from the front end: either a finished marker or one midpoint step.
   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [STEP_W-1:0]         x;
      logic [STEP_W-1:0]         y;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

// ===== rtl/core/mcf_front.sv =====
// Front end: takes requests, keeps the circle and midpoint walk state, issues commands.
// Depends on mcf_pkg.
`timescale 1ns / 1ps

module mcf_front import mcf_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      action,
   input  logic signed [COORD_W-1:0] center_x,
   input  logic signed [COORD_W-1:0] center_y,
   input  logic [RAD_W-1:0]          radius,
   output logic                      cmd_push,
   output cmd_type                   cmd
);

   localparam int X_W   = RADIUS_BITS + 2;
   localparam int Y_W   = RADIUS_BITS + 1;
   localparam int ERR_W = RADIUS_BITS + 4;

   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [X_W-1:0]     x_ff, x_in;
   logic [Y_W-1:0]            y_ff, y_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      busy_ff, busy_in;

   logic [RADIUS_BITS-1:0]    r_val;
   logic [Y_W-1:0]            y_next;
   logic signed [X_W-1:0]     x_dec;
   logic signed [ERR_W-1:0]   y_next_e;
   logic signed [ERR_W-1:0]   x_dec_e;
   logic signed [ERR_W-1:0]   err_add;
   logic                      walk_done;
   logic                      is_advance;

   always_comb begin
      r_val      = RADIUS_BITS'(radius);
      is_advance = (action_type'(action) == ACT_ADVANCE);
      y_next     = y_ff + Y_W'(1);
      x_dec      = x_ff - X_W'(1);
      y_next_e   = ERR_W'(y_next);
      x_dec_e    = ERR_W'(x_dec);
      walk_done  = !busy_ff || (x_ff < $signed({1'b0, y_ff}));
      if (err_ff[ERR_W-1]) begin
         err_add = y_next_e + y_next_e + ERR_W'(1);
      end else begin
         err_add = (y_next_e - x_dec_e + ERR_W'(1)) + (y_next_e - x_dec_e + ERR_W'(1));
      end

      cx_in   = cx_ff;
      cy_in   = cy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      err_in  = err_ff;
      busy_in = busy_ff;
      if (accept) begin
         if (!is_advance) begin
            cx_in   = center_x;
            cy_in   = center_y;
            x_in    = X_W'(r_val);
            y_in    = '0;
            err_in  = ERR_W'(1) - ERR_W'(r_val);
            busy_in = 1'b1;
         end else if (walk_done) begin
            busy_in = 1'b0;
         end else begin
            y_in   = y_next;
            err_in = err_ff + err_add;
            // A non-negative error moves the walk one column inward.
            if (!err_ff[ERR_W-1]) begin
               x_in = x_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         x_ff    <= '0;
         y_ff    <= '0;
         err_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         err_ff  <= err_in;
         busy_ff <= busy_in;
      end
   end

   // Spans are only issued while x >= y >= 0, so the low radius bits hold both.
   always_comb begin
      cmd_push = accept && is_advance;
      cmd.done = walk_done;
      cmd.cx   = cx_ff;
      cmd.cy   = cy_ff;
      cmd.x    = STEP_W'(x_ff[RADIUS_BITS-1:0]);
      cmd.y    = STEP_W'(y_ff[RADIUS_BITS-1:0]);
   end

endmodule

// ===== rtl/core/mcf_queue.sv =====
// Short first-in first-out queue of commands between the front and back ends.
// Generic width and depth; depends on nothing.
`timescale 1ns / 1ps

module mcf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       q_full,
   output logic                       q_empty,
   output logic [$clog2(DEPTH+1)-1:0] q_count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   always_comb begin
      q_full  = (count_ff == CNT_W'(DEPTH));
      q_empty = (count_ff == '0);
      q_count = count_ff;
      rd_data = slot_ff[rd_ptr_ff];
      do_wr   = wr_en && !q_full;
      do_rd   = rd_en && !q_empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/mcf_back.sv =====
// Back end: expands each queued command into four spans or one done result.
// Holds the result register on the output side; depends on mcf_pkg.
`timescale 1ns / 1ps

module mcf_back import mcf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  head,
   input  logic                     head_valid,
   output logic                     head_pop,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [SPAN_W-1:0] span_row,
   output logic signed [SPAN_W-1:0] span_left,
   output logic signed [SPAN_W-1:0] span_right,
   output logic                     last_of_step,
   output logic                     done_res
);

   logic [1:0]               phase_ff, phase_in;
   logic                     valid_ff, valid_in;
   logic signed [SPAN_W-1:0] row_ff, row_in;
   logic signed [SPAN_W-1:0] left_ff, left_in;
   logic signed [SPAN_W-1:0] right_ff, right_in;
   logic                     last_ff, last_in;
   logic                     done_ff, done_in;

   logic                     load;
   logic                     final_phase;
   logic signed [SPAN_W-1:0] cx_e;
   logic signed [SPAN_W-1:0] cy_e;
   logic signed [SPAN_W-1:0] row_off;
   logic signed [SPAN_W-1:0] col_off;

   always_comb begin
      load        = head_valid && (!valid_ff || pop);
      final_phase = head.done || (phase_ff == 2'd3);
      head_pop    = load && final_phase;

      cx_e = SPAN_W'(head.cx);
      cy_e = SPAN_W'(head.cy);
      // Odd phases swap the roles of x and y; the upper two phases mirror the row.
      row_off = phase_ff[0] ? SPAN_W'(head.x) : SPAN_W'(head.y);
      col_off = phase_ff[0] ? SPAN_W'(head.y) : SPAN_W'(head.x);

      phase_in = phase_ff;
      valid_in = valid_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = final_phase ? 2'd0 : phase_ff + 2'd1;
         last_in  = final_phase;
         done_in  = head.done;
         if (head.done) begin
            row_in   = '0;
            left_in  = '0;
            right_in = '0;
         end else begin
            row_in   = phase_ff[1] ? cy_e - row_off : cy_e + row_off;
            left_in  = cx_e - col_off;
            right_in = cx_e + col_off;
         end
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign empty        = !valid_ff;
   assign span_row     = row_ff;
   assign span_left    = left_ff;
   assign span_right   = right_ff;
   assign last_of_step = last_ff;
   assign done_res     = done_ff;

endmodule

// ===== rtl/core/midpoint_circle_fill_spans.sv =====
// Top level of the filled-circle span generator: front end, command queue, back end.
// Depends on mcf_pkg, mcf_front, mcf_queue and mcf_back.
//
//   channel   ports                               handshake
//   request   req_action, req_center_*, req_radius push / full
//   result    rsp_span_*, rsp_last_of_step,       empty / pop
//             rsp_done_res
//
// A request is taken in the cycle it is pushed while full is low; start requests give
// no result. An advance becomes one queued command; the back end turns it into four
// spans at one per cycle while results are popped (or one done result); the single
// span output register sets the steady advance rate. While a result waits unpopped
// the back end holds its command; the queue then fills and full rises. Synchronous
// reset clears all control state; full rises only when the command queue is full.
`timescale 1ns / 1ps

module midpoint_circle_fill_spans import mcf_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int CMD_DEPTH   = CMD_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_action,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RAD_W-1:0]         req_radius,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [SPAN_W-1:0] rsp_span_row,
   output logic signed [SPAN_W-1:0] rsp_span_left,
   output logic signed [SPAN_W-1:0] rsp_span_right,
   output logic                     rsp_last_of_step,
   output logic                     rsp_done_res
);

   logic                         accept;
   logic                         cmd_push;
   cmd_type                      cmd_in;
   cmd_type                      cmd_head;
   logic                         q_full;
   logic                         q_empty;
   logic [$clog2(CMD_DEPTH+1)-1:0] q_count;
   logic                         head_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   mcf_front #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_action),
      .center_x(req_center_x),
      .center_y(req_center_y),
      .radius  (req_radius),
      .cmd_push(cmd_push),
      .cmd     (cmd_in)
   );

   mcf_queue #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_push),
      .wr_data(cmd_in),
      .rd_en  (head_pop),
      .rd_data(cmd_head),
      .q_full (q_full),
      .q_empty(q_empty),
      .q_count(q_count)
   );

   mcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (cmd_head),
      .head_valid  (!q_empty),
      .head_pop    (head_pop),
      .empty       (empty),
      .pop         (pop),
      .span_row    (rsp_span_row),
      .span_left   (rsp_span_left),
      .span_right  (rsp_span_right),
      .last_of_step(rsp_last_of_step),
      .done_res    (rsp_done_res)
   );

   // Every accepted advance leaves a command in the queue after the edge.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_ADVANCE)) |=> !q_empty)
   else $error("advance request did not reach the command queue");

   assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH))
   else $error("command queue count exceeds its depth");

   // A done result closes its request and carries no span.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_done_res) |-> (rsp_last_of_step && (rsp_span_row == '0)
         && (rsp_span_left == '0) && (rsp_span_right == '0)))
   else $error("done result with span data or without last flag");

   // The back end pops the queue only on the last result of a command.
   assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (!empty && rsp_last_of_step))
   else $error("command retired without its last result");

endmodule
